// ----- src/dofprf_pkg.sv -----
// ----------------------------------------------------------------------------
// dofprf_pkg
// Shared constants, types and helpers of the drop-on-full packet ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package dofprf_pkg;

	// Ring geometry.
	localparam int RING_DEPTH  = 64;
	localparam int ENTRY_WORDS = 4;

	localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W   = SLOT_W + 1;
	localparam int WIDX_W  = (ENTRY_WORDS > 1) ? $clog2(ENTRY_WORDS) : 1;
	localparam int ADDR_W  = (RING_DEPTH * ENTRY_WORDS > 1) ?
		$clog2(RING_DEPTH * ENTRY_WORDS) : 1;
	localparam int MEM_DEPTH = RING_DEPTH * ENTRY_WORDS;

	// Fixed field widths of the channels.
	localparam int WORD_W = 32;
	localparam int KIND_W = 2;
	localparam int FILL_W = 6;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [WIDX_W-1:0] widx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [FILL_W-1:0] fill_t;

	// Request commands.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result kinds.
	localparam kind_t KIND_PUSH_DONE = 2'd0;
	localparam kind_t KIND_POP_WORD  = 2'd1;
	localparam kind_t KIND_POP_EMPTY = 2'd2;

	// Entries held: (head - tail) modulo the ring depth.
	function automatic slot_t fill_of(slot_t head, slot_t tail);
		logic [CNT_W-1:0] sum;
		begin
			sum = {1'b0, head} + CNT_W'(RING_DEPTH) - {1'b0, tail};
			if (head >= tail) begin
				return head - tail;
			end
			return sum[SLOT_W-1:0];
		end
	endfunction

	// Next slot index with wrap at the ring depth.
	function automatic slot_t slot_inc(slot_t s);
		begin
			if (s == SLOT_W'(RING_DEPTH - 1)) begin
				return '0;
			end
			return s + 1'b1;
		end
	endfunction

endpackage

`default_nettype wire

// ----- src/dofprf_in_if.sv -----
// ----------------------------------------------------------------------------
// dofprf_in_if
// Request channel: one push word or one pop command per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface dofprf_in_if;

	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [dofprf_pkg::WORD_W-1:0] push_word;

	modport source (output valid, output command, output push_word, input ready);
	modport sink   (input valid, input command, input push_word, output ready);

endinterface

`default_nettype wire

// ----- src/dofprf_out_if.sv -----
// ----------------------------------------------------------------------------
// dofprf_out_if
// Result channel: push completions, popped words and empty notices.
// ----------------------------------------------------------------------------
`default_nettype none

interface dofprf_out_if;

	logic                          valid;
	logic                          ready;
	logic [dofprf_pkg::KIND_W-1:0] kind;
	logic                          accepted;
	logic [dofprf_pkg::WORD_W-1:0] pop_word;
	logic                          last_word;
	logic [dofprf_pkg::FILL_W-1:0] fill_count;
	logic [dofprf_pkg::WORD_W-1:0] lost_count;
	logic [dofprf_pkg::FILL_W-1:0] max_fill;

	modport source (output valid, output kind, output accepted, output pop_word,
		output last_word, output fill_count, output lost_count, output max_fill,
		input ready);
	modport sink (input valid, input kind, input accepted, input pop_word,
		input last_word, input fill_count, input lost_count, input max_fill,
		output ready);

endinterface

`default_nettype wire

// ----- src/drop_on_full_packet_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// drop_on_full_packet_ring_fifo
// Ring FIFO of fixed-size entries that drops whole entries when full.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_ch. A push request carries one word of an entry;
// ENTRY_WORDS pushes make one entry. The drop decision is taken at the first
// word of an entry; the last word commits a kept entry and returns one completion.
// A pop request returns the oldest entry as ENTRY_WORDS word results, or one
// empty result. Every result carries fill count, lost count and high-water.
// A push completion or an empty result appears on out_ch in the cycle after its
// request is taken; the first word of a popped entry is read into the registered
// memory output and then loaded into the output register.
// After a push word or an empty pop the next request can be taken unless a
// result is stalled by out_ch.ready. A pop of a held entry takes the request,
// then for each word one read of the entry memory read port, which is
// registered, and one load of the output register.
// in_ch.ready is low while a pop is being read out and while a waiting
// result is stalled by out_ch.ready; a stalled result holds its value.
// Reset clears pointers, counters and the output valid flag; the entry memory
// is not cleared and is only read at entries that were written.
// ----------------------------------------------------------------------------
`default_nettype none

module drop_on_full_packet_ring_fifo (
	input  wire        clk,
	input  wire        arst_n,
	dofprf_in_if.sink   in_ch,
	dofprf_out_if.source out_ch
);

	import dofprf_pkg::*;

	// Pop sequencer states.
	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_POP_READ = 2'd1;
	localparam logic [1:0] ST_POP_LOAD = 2'd2;

	logic [1:0] state_q;

	// Ring state.
	slot_t       head_q;
	slot_t       tail_q;
	word_t       lost_q;
	slot_t       high_water_q;
	widx_t       widx_q;
	logic        dropping_q;

	// Pop readout.
	addr_t       pop_addr_q;
	widx_t       pop_cnt_q;
	word_t       rd_data_q;

	// Output register.
	logic        out_valid_q;
	kind_t       out_kind_q;
	logic        out_acc_q;
	word_t       out_word_q;
	logic        out_last_q;
	fill_t       out_fill_q;
	word_t       out_lost_q;
	fill_t       out_max_q;

	// Entry memory.
	word_t       mem [MEM_DEPTH];

	logic        out_free;
	logic        in_fire;
	logic        push_fire;
	logic        pop_fire;
	logic        first_word;
	logic        last_push;
	slot_t       head_inc;
	logic        drop_first;
	logic        drop_eff;
	logic        ring_empty;
	logic        commit;
	slot_t       commit_fill;
	slot_t       head_n;
	slot_t       tail_n;
	word_t       lost_n;
	slot_t       hw_n;
	logic        mem_we;
	addr_t       mem_waddr;
	logic        mem_re;
	logic        pop_last;
	logic        load_result;

	// Handshake decode.
	assign out_free   = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign in_fire    = in_ch.valid && in_ch.ready;
	assign push_fire  = in_fire && (in_ch.command == CMD_PUSH);
	assign pop_fire   = in_fire && (in_ch.command == CMD_POP);

	// Push word bookkeeping and the drop decision at the first word.
	assign first_word = (widx_q == '0);
	assign last_push  = (widx_q == WIDX_W'(ENTRY_WORDS - 1));
	assign head_inc   = slot_inc(head_q);
	assign drop_first = (head_inc == tail_q);
	assign drop_eff   = first_word ? drop_first : dropping_q;
	assign ring_empty = (head_q == tail_q);
	assign commit     = push_fire && last_push && !drop_eff;
	assign commit_fill = fill_of(head_inc, tail_q);

	// Next values of the ring state after this request.
	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		lost_n = lost_q;
		hw_n   = high_water_q;
		if (push_fire && first_word && drop_first) begin
			lost_n = lost_q + 1'b1;
		end
		if (commit) begin
			head_n = head_inc;
			if (commit_fill > high_water_q) begin
				hw_n = commit_fill;
			end
		end
		if (pop_fire && !ring_empty) begin
			tail_n = slot_inc(tail_q);
		end
	end

	// Memory port controls.
	assign mem_we    = push_fire && !drop_eff;
	assign mem_waddr = ADDR_W'(head_q) * ADDR_W'(ENTRY_WORDS) + ADDR_W'(widx_q);
	assign mem_re    = (state_q == ST_POP_READ) && out_free;
	assign pop_last  = (pop_cnt_q == WIDX_W'(ENTRY_WORDS - 1));

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= in_ch.push_word;
		end
		if (mem_re) begin
			rd_data_q <= mem[pop_addr_q];
		end
	end

	// Ring pointers, counters and push assembly state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			lost_q       <= '0;
			high_water_q <= '0;
			widx_q       <= '0;
			dropping_q   <= 1'b0;
		end else begin
			head_q       <= head_n;
			tail_q       <= tail_n;
			lost_q       <= lost_n;
			high_water_q <= hw_n;
			if (push_fire) begin
				if (first_word) begin
					dropping_q <= drop_first;
				end
				widx_q <= last_push ? '0 : widx_q + 1'b1;
			end
		end
	end

	// Pop sequencer: for each word, issue one read, then load its word into the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pop_addr_q <= '0;
			pop_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_fire && !ring_empty) begin
						pop_addr_q <= ADDR_W'(tail_q) * ADDR_W'(ENTRY_WORDS);
						pop_cnt_q  <= '0;
						state_q    <= ST_POP_READ;
					end
				end
				ST_POP_READ: begin
					if (mem_re) begin
						state_q <= ST_POP_LOAD;
					end
				end
				ST_POP_LOAD: begin
					if (pop_last) begin
						state_q <= ST_IDLE;
					end else begin
						pop_cnt_q  <= pop_cnt_q + 1'b1;
						pop_addr_q <= pop_addr_q + 1'b1;
						state_q    <= ST_POP_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	assign load_result = (in_fire && ((in_ch.command == CMD_POP) ? ring_empty : last_push))
		|| (state_q == ST_POP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; the status fields show the state after the request.
	always_ff @(posedge clk) begin
		if (load_result) begin
			out_fill_q <= FILL_W'(fill_of(head_n, tail_n));
			out_lost_q <= lost_n;
			out_max_q  <= FILL_W'(hw_n);
			if (state_q == ST_POP_LOAD) begin
				out_kind_q <= KIND_POP_WORD;
				out_acc_q  <= 1'b0;
				out_word_q <= rd_data_q;
				out_last_q <= pop_last;
			end else if (in_ch.command == CMD_POP) begin
				out_kind_q <= KIND_POP_EMPTY;
				out_acc_q  <= 1'b0;
				out_word_q <= '0;
				out_last_q <= 1'b1;
			end else begin
				out_kind_q <= KIND_PUSH_DONE;
				out_acc_q  <= !drop_eff;
				out_word_q <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.kind       = out_kind_q;
	assign out_ch.accepted   = out_acc_q;
	assign out_ch.pop_word   = out_word_q;
	assign out_ch.last_word  = out_last_q;
	assign out_ch.fill_count = out_fill_q;
	assign out_ch.lost_count = out_lost_q;
	assign out_ch.max_fill   = out_max_q;

	// The high-water mark never falls below the current fill.
	a_hw_covers_fill: assert property (@(posedge clk) disable iff (!arst_n)
		high_water_q >= fill_of(head_q, tail_q))
		else $error("high-water mark below current fill");

	// A popped word is loaded only into an empty output register.
	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_LOAD) |-> !out_valid_q)
		else $error("popped word would overwrite a pending result");

	// The lost count moves only on a push at the first word of an entry.
	a_lost_on_first: assert property (@(posedge clk) disable iff (!arst_n)
		(lost_q != $past(lost_q)) |-> $past(push_fire && first_word))
		else $error("lost count changed outside a first push word");

	// The ring pointers do not move while a pop is being read out.
	a_no_req_in_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (tail_q == $past(tail_q)) && (head_q == $past(head_q)))
		else $error("ring pointers moved during a pop readout");

endmodule

`default_nettype wire
